@@ sv/mats_pkg.sv @@
package mats_pkg;

    localparam int MATS_CHANNELS    = 9;
    localparam int MATS_TICK_DIVIDE = 3;

    // result actions
    localparam logic [1:0] ACT_PASS  = 2'd0;
    localparam logic [1:0] ACT_DROP  = 2'd1;
    localparam logic [1:0] ACT_VALUE = 2'd2;

    // status high nibbles
    localparam logic [3:0] KIND_NOTE_OFF   = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON    = 4'h9;
    localparam logic [3:0] KIND_AFTERTOUCH = 4'hD;

    // register indexes
    localparam logic [2:0] REG_START_MODE = 3'd0;
    localparam logic [2:0] REG_FADE_IN    = 3'd1;
    localparam logic [2:0] REG_FADE_OUT   = 3'd2;
    localparam logic [2:0] REG_EMIT_CC    = 3'd3;
    localparam logic [2:0] REG_CONTROLLER = 3'd4;

    localparam logic [7:0] START_MODE_RST = 8'd1;
    localparam logic [6:0] FADE_RST       = 7'd8;
    localparam logic [6:0] CONTROLLER_RST = 7'd1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] status_byte;
        logic [6:0] data_one;
        logic [6:0] data_two;
    } item_t;

    typedef struct packed {
        logic [1:0] action;
        logic       is_control_change;
        logic [3:0] out_channel;
        logic [6:0] out_controller;
        logic [6:0] out_value;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [7:0] start_mode;
        logic [6:0] fade_in;
        logic [6:0] fade_out;
        logic       emit_cc;
        logic [6:0] controller_number;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic count_down;
        logic tick_start;
        logic msg_exec;
        logic pass_emit;
        logic tick_step;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic cnt_zero;
        logic two_results;
        logic out_free;
        logic step_hold;
        logic idx_last;
        logic pend_valid;
    } sts_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PASS,
        ST_TICK,
        ST_FLUSH
    } ctrl_state_t;

    function automatic result_t plain_result(input logic [1:0] action, input logic [3:0] ch);
        result_t r;
        r             = '0;
        r.action      = action;
        r.out_channel = ch;
        r.last        = 1'b1;
        return r;
    endfunction

    function automatic result_t value_result(input cfg_t cfg, input logic [3:0] ch,
                                             input logic [6:0] val);
        result_t r;
        r                   = '0;
        r.action            = ACT_VALUE;
        r.is_control_change = cfg.emit_cc;
        r.out_controller    = cfg.emit_cc ? cfg.controller_number : 7'd0;
        r.out_channel       = ch;
        r.out_value         = val;
        r.last              = 1'b0;
        return r;
    endfunction

endpackage

@@ sv/mats_ctrl.sv @@
module mats_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  mats_pkg::sts_t sts,
    output mats_pkg::cmd_t cmd
);
    import mats_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.is_tick)
                begin
                    state_next = sts.cnt_zero ? ST_TICK : ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    state_next = sts.two_results ? ST_PASS : ST_IDLE;
                end
            end
            ST_PASS:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (!sts.step_hold && sts.idx_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!sts.pend_valid || sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall  = 1'b0;
                cmd.capture = item_valid;
            end
            ST_DECODE:
            begin
                if (sts.is_tick)
                begin
                    cmd.tick_start = sts.cnt_zero;
                    cmd.count_down = !sts.cnt_zero;
                end
                else
                begin
                    cmd.msg_exec = sts.out_free;
                end
            end
            ST_PASS:
            begin
                cmd.pass_emit = sts.out_free;
            end
            ST_TICK:
            begin
                cmd.tick_step = !sts.step_hold;
            end
            ST_FLUSH:
            begin
                cmd.flush = sts.pend_valid && sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ sv/mats_dp.sv @@
module mats_dp #(
    parameter int CHANNELS    = mats_pkg::MATS_CHANNELS,
    parameter int TICK_DIVIDE = mats_pkg::MATS_TICK_DIVIDE
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mats_pkg::item_t  item,
    output mats_pkg::result_t result,
    output logic             result_valid,
    input  logic             result_stall,
    input  mats_pkg::cfg_t   cfg,
    input  mats_pkg::cmd_t   cmd,
    output mats_pkg::sts_t   sts
);
    import mats_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    item_t            item_reg;
    logic [CH_W-1:0]  idx_reg;
    logic [1:0]       cnt_reg;
    logic [7:0]       held_reg   [CHANNELS];
    logic [10:0]      smooth_reg [CHANNELS];
    logic [6:0]       target_reg [CHANNELS];
    logic [6:0]       sent_reg   [CHANNELS];
    result_t          pend_reg;
    logic             pend_valid_reg;
    logic             pend_valid_next;
    result_t          out_reg;
    result_t          out_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_load;
    logic             out_free;

    // message path
    logic [3:0]       m_ch;
    logic [3:0]       m_kind;
    logic             m_in_range;
    logic [CH_W-1:0]  m_idx;
    logic [7:0]       m_held;
    logic             m_first;
    logic [6:0]       m_seed;

    // tick path
    logic [7:0]         t_held;
    logic [10:0]        t_smooth;
    logic [6:0]         t_target;
    logic signed [11:0] t_diff;
    logic signed [11:0] t_half;
    logic signed [11:0] t_lim_up;
    logic signed [11:0] t_lim_dn;
    logic signed [11:0] t_step;
    logic [11:0]        t_sum;
    logic [10:0]        t_new;
    logic [6:0]         t_val;
    logic               t_changed;

    assign m_ch       = item_reg.status_byte[3:0];
    assign m_kind     = item_reg.status_byte[7:4];
    assign m_in_range = {1'b0, m_ch} < 5'(CHANNELS);
    assign m_idx      = m_ch[CH_W-1:0];
    assign m_held     = m_in_range ? held_reg[m_idx] : 8'd0;
    assign m_first    = (m_kind == KIND_NOTE_ON) && m_in_range && (m_held == 8'd0);

    always_comb
    begin
        priority if (cfg.start_mode == 8'd1)
        begin
            m_seed = item_reg.data_two;
        end
        else if (cfg.start_mode < 8'd2)
        begin
            m_seed = 7'd0;
        end
        else if (cfg.start_mode > 8'd129)
        begin
            m_seed = 7'd127;
        end
        else
        begin
            m_seed = 7'(cfg.start_mode - 8'd2);
        end
    end

    // half the distance, rounded toward minus infinity, then slew clamp
    assign t_held   = held_reg[idx_reg];
    assign t_smooth = smooth_reg[idx_reg];
    assign t_target = target_reg[idx_reg];
    assign t_diff   = $signed({1'b0, t_target, 4'b0000}) - $signed({1'b0, t_smooth});
    assign t_half   = t_diff >>> 1;
    assign t_lim_up = $signed({3'b000, cfg.fade_in, 2'b00});
    assign t_lim_dn = -$signed({3'b000, cfg.fade_out, 2'b00});

    always_comb
    begin
        if (t_half > 12'sd0)
        begin
            t_step = (t_half > t_lim_up) ? t_lim_up : t_half;
        end
        else
        begin
            t_step = (t_half < t_lim_dn) ? t_lim_dn : t_half;
        end
    end

    assign t_sum     = {1'b0, t_smooth} + $unsigned(t_step);
    assign t_new     = t_sum[10:0];
    assign t_val     = t_new[10:4];
    assign t_changed = (t_held != 8'd0) && (t_val != sent_reg[idx_reg]);

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        sts             = '0;
        sts.is_tick     = item_reg.req_type;
        sts.cnt_zero    = (cnt_reg == 2'd0);
        sts.two_results = m_first;
        sts.out_free    = out_free;
        sts.step_hold   = t_changed && pend_valid_reg && !out_free;
        sts.idx_last    = (idx_reg == CH_W'(CHANNELS - 1));
        sts.pend_valid  = pend_valid_reg;
    end

    always_comb
    begin
        out_load = 1'b0;
        out_next = out_reg;
        if (cmd.msg_exec)
        begin
            out_load = 1'b1;
            if (m_kind == KIND_AFTERTOUCH)
            begin
                out_next = plain_result(ACT_DROP, m_ch);
            end
            else if (m_first)
            begin
                out_next = value_result(cfg, m_ch, m_seed);
            end
            else
            begin
                out_next = plain_result(ACT_PASS, m_ch);
            end
        end
        else if (cmd.pass_emit)
        begin
            out_load = 1'b1;
            out_next = plain_result(ACT_PASS, m_ch);
        end
        else if (cmd.tick_step && t_changed && pend_valid_reg)
        begin
            out_load = 1'b1;
            out_next = pend_reg;
        end
        else if (cmd.flush)
        begin
            out_load      = 1'b1;
            out_next      = pend_reg;
            out_next.last = 1'b1;
        end
        out_valid_next = out_load || (out_valid_reg && result_stall);
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (cmd.tick_start || cmd.flush)
        begin
            pend_valid_next = 1'b0;
        end
        else if (cmd.tick_step && t_changed)
        begin
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
        if (cmd.tick_step && t_changed)
        begin
            pend_reg <= value_result(cfg, 4'(idx_reg), t_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            idx_reg        <= '0;
            cnt_reg        <= 2'd0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (cmd.tick_start)
            begin
                idx_reg <= '0;
                cnt_reg <= 2'(TICK_DIVIDE - 1);
            end
            else if (cmd.count_down)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
            else if (cmd.tick_step)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // per-channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                held_reg[i]   <= 8'd0;
                smooth_reg[i] <= 11'd0;
                target_reg[i] <= 7'd0;
                sent_reg[i]   <= 7'd0;
            end
        end
        else
        begin
            if (cmd.msg_exec && m_in_range)
            begin
                unique case (m_kind)
                    KIND_AFTERTOUCH:
                    begin
                        if (m_held != 8'd0)
                        begin
                            target_reg[m_idx] <= item_reg.data_one;
                        end
                    end
                    KIND_NOTE_OFF:
                    begin
                        if (m_held != 8'd0)
                        begin
                            held_reg[m_idx] <= m_held - 8'd1;
                        end
                    end
                    KIND_NOTE_ON:
                    begin
                        if (m_held != 8'hFF)
                        begin
                            held_reg[m_idx] <= m_held + 8'd1;
                        end
                        if (m_first)
                        begin
                            target_reg[m_idx] <= m_seed;
                            smooth_reg[m_idx] <= {m_seed, 4'b0000};
                            sent_reg[m_idx]   <= m_seed;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.tick_step && (t_held != 8'd0))
            begin
                smooth_reg[idx_reg] <= t_new;
                if (t_changed)
                begin
                    sent_reg[idx_reg] <= t_val;
                end
            end
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

@@ sv/midi_aftertouch_slew_smoother.sv @@
// Channel-aftertouch slew smoother for MIDI channels 0 .. CHANNELS-1.
// Input channel (item_valid / item_stall / item): a MIDI message or a tick,
// one beat each. Output channel (result_valid / result_stall / result):
// one or more result beats per message, the final one marked by last; a tick
// gives one beat per channel whose value changed, or none at all.
// The block works on one item at a time; item_stall is low only while idle.
// A message is decoded once accepted and loads its first result into the
// output register when that is free; a first note-on then adds a pass beat.
// A tick only counts the divider down while it is still counting, else the
// slew unit visits one channel entry per cycle unless the output stall holds it.
// The result beat sits in an output register; while the receiver stalls it
// holds, and the block keeps working until it needs that register again.
// The user must write settings over the APB port only while idle; the block
// does not enforce this. pready is always high. Reset clears all channel
// state, the tick divider and the output, and loads the register defaults.
module midi_aftertouch_slew_smoother #(
    parameter int CHANNELS    = mats_pkg::MATS_CHANNELS,
    parameter int TICK_DIVIDE = mats_pkg::MATS_TICK_DIVIDE
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  mats_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output mats_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import mats_pkg::*;

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_mode        <= START_MODE_RST;
            cfg_reg.fade_in           <= FADE_RST;
            cfg_reg.fade_out          <= FADE_RST;
            cfg_reg.emit_cc           <= 1'b0;
            cfg_reg.controller_number <= CONTROLLER_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_START_MODE: cfg_reg.start_mode        <= pwdata[7:0];
                REG_FADE_IN:    cfg_reg.fade_in           <= pwdata[6:0];
                REG_FADE_OUT:   cfg_reg.fade_out          <= pwdata[6:0];
                REG_EMIT_CC:    cfg_reg.emit_cc           <= pwdata[0];
                REG_CONTROLLER: cfg_reg.controller_number <= pwdata[6:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_START_MODE: prdata = {24'd0, cfg_reg.start_mode};
            REG_FADE_IN:    prdata = {25'd0, cfg_reg.fade_in};
            REG_FADE_OUT:   prdata = {25'd0, cfg_reg.fade_out};
            REG_EMIT_CC:    prdata = {31'd0, cfg_reg.emit_cc};
            REG_CONTROLLER: prdata = {25'd0, cfg_reg.controller_number};
            default:        prdata = 32'd0;
        endcase
    end

    mats_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    mats_dp #(
        .CHANNELS    (CHANNELS),
        .TICK_DIVIDE (TICK_DIVIDE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

@@ sv/mats_chk.sv @@
module mats_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input mats_pkg::result_t result,
    input logic              result_valid,
    input logic              result_stall
);
    import mats_pkg::*;

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result beat changed");

    // one item at a time: busy right after an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input accepted while busy");

    // pass and drop always close the item
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.action != ACT_VALUE) |-> result.last)
        else $error("pass or drop result not marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.action != ACT_VALUE)
            |-> (result.out_value == 7'd0) && (result.out_controller == 7'd0)
                && !result.is_control_change)
        else $error("unused fields of pass or drop not zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.action == ACT_VALUE) && !result.is_control_change
            |-> result.out_controller == 7'd0)
        else $error("controller set on aftertouch result");

endmodule

bind midi_aftertouch_slew_smoother mats_chk u_mats_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
);
